@@ rtl/core/ccu_pkg.sv @@
// ----------------------------------------------------------------------------
// ccu_pkg
// Shared types for the coprime counter core: sequencer states and the
// status word of the bit-serial arithmetic units.
// ----------------------------------------------------------------------------
package ccu_pkg;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_TRIAL,
		ST_STRIP,
		ST_FINAL,
		ST_SUB_START,
		ST_SUB_SCAN,
		ST_SUB_MUL,
		ST_SUB_DIV,
		ST_OUT
	} ccu_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} ccu_unit_stat_t;

endpackage

@@ rtl/core/ccu_if.sv @@
// ----------------------------------------------------------------------------
// ccu_if
// Valid/ready channels of the coprime counter: input value, result count and
// limit register write.
// ----------------------------------------------------------------------------
interface ccu_value_if #(parameter int DATA_WIDTH = 32);
	logic                  valid;
	logic                  ready;
	logic [DATA_WIDTH-1:0] value;
	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

interface ccu_count_if #(parameter int DATA_WIDTH = 32);
	logic                  valid;
	logic                  ready;
	logic [DATA_WIDTH-1:0] coprime_count;
	modport source (output valid, output coprime_count, input ready);
	modport sink   (input valid, input coprime_count, output ready);
endinterface

interface ccu_limit_if #(parameter int DATA_WIDTH = 32);
	logic                  valid;
	logic                  ready;
	logic [DATA_WIDTH-1:0] limit;
	modport source (output valid, output limit, input ready);
	modport sink   (input valid, input limit, output ready);
endinterface

@@ rtl/core/ccu_div.sv @@
// ----------------------------------------------------------------------------
// ccu_div
// Restoring divider, one quotient bit per cycle. Quotient and remainder are
// valid in the cycle done is high.
// ----------------------------------------------------------------------------
module ccu_div #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [DATA_WIDTH-1:0]  dividend,
	input  logic [DATA_WIDTH-1:0]  divisor,
	output logic [DATA_WIDTH-1:0]  quotient,
	output logic [DATA_WIDTH-1:0]  remainder,
	output ccu_pkg::ccu_unit_stat_t stat
);
	import ccu_pkg::*;

	localparam int CW = (DATA_WIDTH > 1) ? $clog2(DATA_WIDTH) : 1;

	logic [DATA_WIDTH-1:0] rem_q, quo_q, den_q;
	logic [CW-1:0]         cnt_q;
	logic                  busy_q, done_q;
	logic [DATA_WIDTH:0]   sh, diff;
	logic                  ge;
	logic [DATA_WIDTH-1:0] rem_nx;

	always_comb begin
		sh     = {rem_q, quo_q[DATA_WIDTH-1]};
		diff   = sh - {1'b0, den_q};
		ge     = sh >= {1'b0, den_q};
		rem_nx = ge ? diff[DATA_WIDTH-1:0] : sh[DATA_WIDTH-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(DATA_WIDTH - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			den_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_nx;
			quo_q <= {quo_q[DATA_WIDTH-2:0], ge};
		end
	end

	assign quotient  = quo_q;
	assign remainder = rem_q;
	assign stat      = '{busy: busy_q, done: done_q};

endmodule

@@ rtl/core/ccu_mul.sv @@
// ----------------------------------------------------------------------------
// ccu_mul
// Shift-and-add multiplier, one multiplier bit per cycle, product truncated
// to the word width. Product is valid in the cycle done is high.
// ----------------------------------------------------------------------------
module ccu_mul #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [DATA_WIDTH-1:0]  op_a,
	input  logic [DATA_WIDTH-1:0]  op_b,
	output logic [DATA_WIDTH-1:0]  product,
	output ccu_pkg::ccu_unit_stat_t stat
);
	import ccu_pkg::*;

	localparam int CW = (DATA_WIDTH > 1) ? $clog2(DATA_WIDTH) : 1;

	logic [DATA_WIDTH-1:0] acc_q, a_q, b_q;
	logic [CW-1:0]         cnt_q;
	logic                  busy_q, done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(DATA_WIDTH - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			a_q   <= op_a;
			b_q   <= op_b;
		end else if (busy_q) begin
			acc_q <= acc_q + (b_q[0] ? a_q : '0);
			a_q   <= {a_q[DATA_WIDTH-2:0], 1'b0};
			b_q   <= {1'b0, b_q[DATA_WIDTH-1:1]};
		end
	end

	assign product = acc_q;
	assign stat    = '{busy: busy_q, done: done_q};

endmodule

@@ rtl/core/coprime_count_up_to_limit_core.sv @@
// ----------------------------------------------------------------------------
// coprime_count_up_to_limit_core
// Counts the integers in 1..limit that are coprime to an input value; a value of zero gives a count of one.
// ----------------------------------------------------------------------------
// One item at a time. Each value is factored by trial division on a bit-serial
// divider: one division per candidate divisor (candidates up to the square
// root of the remaining cofactor) plus one per power of a found prime. The
// count is then summed over all 2^n subsets of the n distinct primes, each
// subset taking up to n serial multiplies and one serial division. A value
// of zero skips the factoring and the subset sum. The result sits in an
// output register, so the next item is taken while it waits.
module coprime_count_up_to_limit_core #(
	parameter int DATA_WIDTH          = 32,
	parameter int MAX_DISTINCT_PRIMES = 9
) (
	input  logic        clk,
	input  logic        arst_n,
	ccu_limit_if.sink   cfg,
	ccu_value_if.sink   req,
	ccu_count_if.source rsp
);
	import ccu_pkg::*;

	localparam int W      = DATA_WIDTH;
	localparam int NP     = MAX_DISTINCT_PRIMES;
	localparam int CNT_W  = $clog2(NP + 1);
	localparam int PIDX_W = (NP > 1) ? $clog2(NP) : 1;

	ccu_state_t state_q, state_nx;

	logic [W-1:0]     limit_q;
	logic [W-1:0]     rest_q, i_q, prod_q, total_q, count_q;
	logic [W-1:0]     primes_q [NP];
	logic [CNT_W-1:0] n_q, j_q;
	logic [NP-1:0]    subset_q, full_mask;
	logic             neg_q, out_valid_q;

	logic             div_start, mul_start;
	logic [W-1:0]     div_a, div_b, div_q, div_r, mul_b, mul_p;
	ccu_unit_stat_t   div_stat, mul_stat;

	logic             accept, out_load, room, subset_last, sel_bit, n_free;
	logic [W-1:0]     i_inc;

	ccu_div #(.DATA_WIDTH(W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_a),
		.divisor  (div_b),
		.quotient (div_q),
		.remainder(div_r),
		.stat     (div_stat)
	);

	ccu_mul #(.DATA_WIDTH(W)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.op_a   (prod_q),
		.op_b   (mul_b),
		.product(mul_p),
		.stat   (mul_stat)
	);

	always_comb begin
		for (int k = 0; k < NP; k++) begin
			full_mask[k] = (CNT_W'(k) < n_q);
		end
	end

	assign subset_last = (subset_q == full_mask);
	assign sel_bit     = subset_q[j_q[PIDX_W-1:0]];
	assign mul_b       = primes_q[j_q[PIDX_W-1:0]];
	assign n_free      = (n_q < CNT_W'(NP));
	assign i_inc       = i_q + W'(1);
	assign room        = !out_valid_q || rsp.ready;
	assign accept      = req.valid && req.ready;

	assign cfg.ready         = 1'b1;
	assign req.ready         = (state_q == ST_IDLE);
	assign rsp.valid         = out_valid_q;
	assign rsp.coprime_count = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx  = state_q;
		div_start = 1'b0;
		div_a     = rest_q;
		div_b     = i_q;
		mul_start = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (req.value == '0) begin
						state_nx = ST_OUT;
					end else begin
						div_start = 1'b1;
						div_a     = req.value;
						div_b     = W'(2);
						state_nx  = ST_TRIAL;
					end
				end
			end
			ST_TRIAL, ST_STRIP: begin
				if (div_stat.done) begin
					if (state_q == ST_TRIAL && div_q < i_q) begin
						state_nx = ST_FINAL;
					end else if (div_r == '0) begin
						div_start = 1'b1;
						div_a     = div_q;
						state_nx  = ST_STRIP;
					end else begin
						div_start = 1'b1;
						div_b     = i_inc;
						state_nx  = ST_TRIAL;
					end
				end
			end
			ST_FINAL: begin
				state_nx = ST_SUB_START;
			end
			ST_SUB_START: begin
				state_nx = ST_SUB_SCAN;
			end
			ST_SUB_SCAN: begin
				if (j_q == n_q) begin
					div_start = 1'b1;
					div_a     = limit_q;
					div_b     = prod_q;
					state_nx  = ST_SUB_DIV;
				end else if (sel_bit) begin
					mul_start = 1'b1;
					state_nx  = ST_SUB_MUL;
				end
			end
			ST_SUB_MUL: begin
				if (mul_stat.done) begin
					state_nx = ST_SUB_SCAN;
				end
			end
			ST_SUB_DIV: begin
				if (div_stat.done) begin
					state_nx = subset_last ? ST_OUT : ST_SUB_START;
				end
			end
			ST_OUT: begin
				if (room) begin
					out_load = 1'b1;
					state_nx = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				limit_q <= cfg.limit;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			count_q <= total_q;
		end
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					rest_q  <= req.value;
					i_q     <= W'(2);
					n_q     <= '0;
					total_q <= W'(1);
				end
			end
			ST_TRIAL, ST_STRIP: begin
				if (div_stat.done && !(state_q == ST_TRIAL && div_q < i_q)) begin
					if (div_r == '0) begin
						rest_q <= div_q;
						if (state_q == ST_TRIAL && n_free) begin
							primes_q[n_q[PIDX_W-1:0]] <= i_q;
							n_q <= n_q + CNT_W'(1);
						end
					end else begin
						i_q <= i_inc;
					end
				end
			end
			ST_FINAL: begin
				if (rest_q > W'(1) && n_free) begin
					primes_q[n_q[PIDX_W-1:0]] <= rest_q;
					n_q <= n_q + CNT_W'(1);
				end
				total_q  <= '0;
				subset_q <= '0;
			end
			ST_SUB_START: begin
				prod_q <= W'(1);
				j_q    <= '0;
				neg_q  <= 1'b0;
			end
			ST_SUB_SCAN: begin
				if (j_q != n_q) begin
					if (sel_bit) begin
						neg_q <= ~neg_q;
					end else begin
						j_q <= j_q + CNT_W'(1);
					end
				end
			end
			ST_SUB_MUL: begin
				if (mul_stat.done) begin
					prod_q <= mul_p;
					j_q    <= j_q + CNT_W'(1);
				end
			end
			ST_SUB_DIV: begin
				if (div_stat.done) begin
					total_q  <= neg_q ? total_q - div_q : total_q + div_q;
					subset_q <= subset_q + NP'(1);
				end
			end
			default: begin
			end
		endcase
	end

endmodule

@@ rtl/core/ccu_checker.sv @@
// ----------------------------------------------------------------------------
// ccu_checker
// Port-level checks of the coprime counter core, bound into the core module.
// ----------------------------------------------------------------------------
module ccu_checker #(
	parameter int DATA_WIDTH = 32
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  req_valid,
	input logic                  req_ready,
	input logic [DATA_WIDTH-1:0] req_value,
	input logic                  rsp_valid,
	input logic                  rsp_ready,
	input logic [DATA_WIDTH-1:0] rsp_count
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result item dropped while stalled");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_count))
		else $error("result item changed while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("ready after accepting an item");

	a_zero_value: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_value == '0 && !rsp_valid
		|=> ##1 (rsp_valid && rsp_count == DATA_WIDTH'(1)))
		else $error("zero value did not give a count of one");

	a_result_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> !$past(req_ready))
		else $error("result item without work in progress");

endmodule

bind coprime_count_up_to_limit_core ccu_checker #(.DATA_WIDTH(DATA_WIDTH)) u_ccu_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req.valid),
	.req_ready(req.ready),
	.req_value(req.value),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.rsp_count(rsp.coprime_count)
);

@@ tb/ccu_tb_if.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ccu_tb_pkg
// Sizes and run limit shared by the coprime counter testbench.
// ----------------------------------------------------------------------------
package ccu_tb_pkg;

	localparam int DW        = 32;
	localparam int MAXP      = 9;
	localparam int MAX_CYCLE = 20000000;

endpackage

@@ tb/tb_coprime_count_up_to_limit_core.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_coprime_count_up_to_limit_core
// Self-checking testbench for the coprime counter core.
// Values are sent in random bursts while the result side stalls on its own
// pattern. Each accepted value is scored against an inclusion-exclusion
// count computed here; the limit register is swept through zero, all ones,
// small and random settings. Values are kept cheap to factor.
// ----------------------------------------------------------------------------
module tb_coprime_count_up_to_limit_core;
	import ccu_tb_pkg::*;

	logic clk;
	logic arst_n;

	ccu_limit_if #(DW) cfg_if ();
	ccu_value_if #(DW) req_if ();
	ccu_count_if #(DW) rsp_if ();

	coprime_count_up_to_limit_core #(
		.DATA_WIDTH          (DW),
		.MAX_DISTINCT_PRIMES (MAXP)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_if),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	logic [DW-1:0] cur_limit;
	logic [DW-1:0] count_queue[$];
	int            mismatches;
	int            values_sent;
	int            counts_seen;
	int            cycles;
	int            burst_left;
	bit            no_gaps;
	bit            rx_stall_mode;
	int            hold_req;
	int            hold_seen;
	int            hold_cnt;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic [DW-1:0] coprime_count_of(logic [DW-1:0] x, logic [DW-1:0] lim);
		logic [63:0] primes[MAXP];
		logic [63:0] rest;
		logic [63:0] i;
		logic [63:0] prod;
		logic [63:0] total;
		int          n;
		int          bits;
		n     = 0;
		total = 0;
		if (x == 0)
			return 1;
		rest = x;
		for (i = 2; i <= rest / i; i++) begin
			if (rest % i == 0) begin
				if (n < MAXP) begin
					primes[n] = i;
					n++;
				end
				while (rest % i == 0)
					rest = rest / i;
			end
		end
		if (rest > 1 && n < MAXP) begin
			primes[n] = rest;
			n++;
		end
		for (int s = 0; s < (1 << n); s++) begin
			prod = 1;
			bits = 0;
			for (int j = 0; j < n; j++) begin
				if ((s >> j) & 1) begin
					prod = prod * primes[j];
					bits++;
				end
			end
			if (bits & 1)
				total = total - {32'd0, lim} / prod;
			else
				total = total + {32'd0, lim} / prod;
		end
		return total[DW-1:0];
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > MAX_CYCLE) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// result side: stall pattern plus long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_if.ready <= 1'b0;
			hold_cnt     <= 0;
			hold_seen    <= 0;
		end else begin
			if (hold_req != hold_seen) begin
				hold_seen <= hold_req;
				hold_cnt  <= 3000;
				rsp_if.ready <= 1'b0;
			end else if (hold_cnt > 0) begin
				hold_cnt <= hold_cnt - 1;
				rsp_if.ready <= 1'b0;
			end else begin
				if ($urandom_range(0, 63) == 0)
					rx_stall_mode <= ~rx_stall_mode;
				rsp_if.ready <= rx_stall_mode ? ($urandom_range(0, 3) != 0) : 1'b1;
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			counts_seen++;
			if (count_queue.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected item: coprime_count=%0d", rsp_if.coprime_count);
			end else begin
				if (rsp_if.coprime_count !== count_queue[0]) begin
					mismatches++;
					if (mismatches <= 10)
						$display("coprime_count mismatch: expected %0d actual %0d",
							count_queue[0], rsp_if.coprime_count);
				end
				void'(count_queue.pop_front());
			end
		end
	end

	task automatic send_value(input logic [DW-1:0] v);
		if (!no_gaps && burst_left <= 0) begin
			req_if.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = $urandom_range(1, 8);
		end
		burst_left--;
		req_if.valid <= 1'b1;
		req_if.value <= v;
		forever begin
			@(negedge clk);
			if (req_if.ready)
				break;
		end
		@(posedge clk);
		count_queue = {count_queue, coprime_count_of(v, cur_limit)};
		values_sent++;
	endtask

	task automatic wait_idle();
		req_if.valid <= 1'b0;
		while (count_queue.size() != 0)
			@(posedge clk);
		repeat (5) @(posedge clk);
	endtask

	task automatic write_limit(input logic [DW-1:0] v);
		wait_idle();
		cfg_if.valid <= 1'b1;
		cfg_if.limit <= v;
		forever begin
			@(negedge clk);
			if (cfg_if.ready)
				break;
		end
		@(posedge clk);
		cur_limit = v;
		cfg_if.valid <= 1'b0;
	endtask

	task automatic send_directed_set();
		logic [DW-1:0] vals[14];
		vals = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd12, 32'd65521,
			32'hFFFFFFFF, 32'h80000000, 32'd223092870, 32'h55555555,
			32'hAAAAAAAA, 32'd30030, 32'd1000};
		foreach (vals[k])
			send_value(vals[k]);
	endtask

	function automatic logic [DW-1:0] cheap_value();
		logic [DW-1:0] base;
		base = $urandom_range(1, 4095);
		if ($urandom_range(0, 15) == 0)
			return 0;
		return base << $urandom_range(0, 20);
	endfunction

	task automatic test_reset_limit();
		send_value(32'd0);
		send_value(32'd1);
		send_value(32'd77);
		wait_idle();
	endtask

	task automatic test_extreme_limits();
		write_limit(32'hFFFFFFFF);
		send_directed_set();
		write_limit(32'd1);
		send_value(32'd0);
		send_value(32'd1);
		send_value(32'd6);
		wait_idle();
	endtask

	task automatic test_backpressure();
		write_limit(32'd100000);
		@(posedge clk);
		hold_req = hold_req + 1;
		no_gaps  = 1'b1;
		repeat (6)
			send_value($urandom_range(1, 255));
		no_gaps = 1'b0;
		wait_idle();
	endtask

	task automatic test_random();
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: write_limit($urandom);
				1: write_limit($urandom_range(0, 200));
				2: write_limit(32'd0);
				default: write_limit($urandom);
			endcase
			no_gaps = (phase == 3);
			repeat (19)
				send_value(cheap_value());
		end
		no_gaps = 1'b0;
		wait_idle();
	endtask

	initial begin
		arst_n        = 1'b0;
		cfg_if.valid  = 1'b0;
		cfg_if.limit  = '0;
		req_if.valid  = 1'b0;
		req_if.value  = '0;
		cur_limit     = '0;
		mismatches    = 0;
		values_sent   = 0;
		counts_seen   = 0;
		cycles        = 0;
		burst_left    = 0;
		no_gaps       = 1'b0;
		rx_stall_mode = 1'b0;
		hold_req      = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_limit();
		test_extreme_limits();
		test_backpressure();
		test_random();
		wait_idle();
		repeat (50) @(posedge clk);
		$display("covered: %0d items sent, %0d counts checked, limits 0/1/max/random,",
			values_sent, counts_seen);
		$display("zero and one values, nine-prime value, long result hold-off");
		if (mismatches == 0 && count_queue.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule

@@ sim.f @@
rtl/core/ccu_pkg.sv
rtl/core/ccu_if.sv
rtl/core/ccu_div.sv
rtl/core/ccu_mul.sv
rtl/core/coprime_count_up_to_limit_core.sv
rtl/core/ccu_checker.sv
tb/ccu_tb_if.sv
tb/tb_coprime_count_up_to_limit_core.sv
